>>> hw/rtl/cc20sx_pkg.sv
// shared types, constants and round functions for the chacha20 stream xor block
package cc20sx_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] block_t;

  // one byte request on either side of the block
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  // configuration register file as seen by the core
  typedef struct packed {
    logic [63:0] key0;
    logic [63:0] key1;
    logic [63:0] key2;
    logic [63:0] key3;
    logic [63:0] nonce;
    logic [63:0] start_ctr;
  } cfg_t;

  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgKey0     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgKey1     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgKey2     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgKey3     = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgNonce    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgStartCtr = 3'd5;

  localparam word_t Sigma0 = 32'h6170_7865;
  localparam word_t Sigma1 = 32'h3320_646e;
  localparam word_t Sigma2 = 32'h7962_2d32;
  localparam word_t Sigma3 = 32'h6b20_6574;

  localparam int NumRounds = 20;
  localparam int RndW      = 5;

  // initial state words for one block
  function automatic block_t init_block(input cfg_t cfg, input logic [63:0] ctr);
    block_t b;
    b[0]  = Sigma0;
    b[1]  = Sigma1;
    b[2]  = Sigma2;
    b[3]  = Sigma3;
    b[4]  = cfg.key0[31:0];
    b[5]  = cfg.key0[63:32];
    b[6]  = cfg.key1[31:0];
    b[7]  = cfg.key1[63:32];
    b[8]  = cfg.key2[31:0];
    b[9]  = cfg.key2[63:32];
    b[10] = cfg.key3[31:0];
    b[11] = cfg.key3[63:32];
    b[12] = ctr[31:0];
    b[13] = ctr[63:32];
    b[14] = cfg.nonce[31:0];
    b[15] = cfg.nonce[63:32];
    return b;
  endfunction

  // half of a quarter round: first half rotates 16/12, second half 8/7
  // result packed as {a, b, c, d}
  function automatic logic [127:0] qr_half(input word_t a, input word_t b,
                                           input word_t c, input word_t d,
                                           input logic second);
    word_t a1;
    word_t b1;
    word_t c1;
    word_t d1;
    word_t dx;
    word_t bx;
    a1 = a + b;
    dx = d ^ a1;
    d1 = second ? {dx[23:0], dx[31:24]} : {dx[15:0], dx[31:16]};
    c1 = c + d1;
    bx = b ^ c1;
    b1 = second ? {bx[24:0], bx[31:25]} : {bx[19:0], bx[31:20]};
    return {a1, b1, c1, d1};
  endfunction

endpackage

>>> hw/rtl/cc20sx_fifo.sv
// small register queue used on both sides of the keystream core
module cc20sx_fifo #(
  parameter int Width = 9,
  parameter int Depth = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [Width-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [Width-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  logic [Width-1:0] mem_r [Depth];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CW'(Depth));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> hw/rtl/cc20sx_core.sv
// keystream generator and byte combiner between the request queues
module cc20sx_core import cc20sx_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  item_t in_item,
  input  logic  in_valid,
  output logic  in_pop,
  output item_t out_item,
  output logic  out_push,
  input  logic  out_full
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROUND,
    S_FEED
  } state_t;

  state_t          state_r, state_nxt;
  block_t          w_r, w_nxt;
  logic [63:0]     blk_ctr_r, blk_ctr_nxt;
  logic [5:0]      pos_r, pos_nxt;
  logic            in_msg_r, in_msg_nxt;
  logic            fresh_r, fresh_nxt;
  logic [RndW-1:0] rnd_r, rnd_nxt;
  logic            half_r, half_nxt;

  logic            need_blk;
  logic [63:0]     ctr_sel;
  word_t           ks_word;
  logic [7:0]      ks_byte;
  block_t          init_w;

  assign need_blk = (!in_msg_r || (pos_r == '0)) && !fresh_r;
  assign ctr_sel  = in_msg_r ? blk_ctr_r : cfg.start_ctr;
  assign ks_word  = w_r[pos_r[5:2]];
  assign ks_byte  = 8'(ks_word >> {pos_r[1:0], 3'b000});
  assign init_w   = init_block(cfg, blk_ctr_r);

  assign out_item.data = in_item.data ^ ks_byte;
  assign out_item.last = in_item.last;

  always_comb begin
    logic [1:0]   jj;
    logic [3:0]   ia;
    logic [3:0]   ib;
    logic [3:0]   ic;
    logic [3:0]   id;
    logic [127:0] q;
    state_nxt   = state_r;
    w_nxt       = w_r;
    blk_ctr_nxt = blk_ctr_r;
    pos_nxt     = pos_r;
    in_msg_nxt  = in_msg_r;
    fresh_nxt   = fresh_r;
    rnd_nxt     = rnd_r;
    half_nxt    = half_r;
    in_pop      = 1'b0;
    out_push    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (need_blk) begin
            w_nxt       = init_block(cfg, ctr_sel);
            blk_ctr_nxt = ctr_sel;
            pos_nxt     = '0;
            rnd_nxt     = '0;
            half_nxt    = 1'b0;
            state_nxt   = S_ROUND;
          end else if (!out_full) begin
            in_pop     = 1'b1;
            out_push   = 1'b1;
            pos_nxt    = pos_r + 1'b1;
            in_msg_nxt = !in_item.last;
            fresh_nxt  = 1'b0;
          end
        end
      end
      S_ROUND: begin
        // four quarter rounds side by side, column or diagonal by round parity
        for (int j = 0; j < 4; j++) begin
          jj = 2'(j);
          ia = {2'b00, jj};
          ib = {2'b01, jj + {1'b0, rnd_r[0]}};
          ic = {2'b10, jj + {rnd_r[0], 1'b0}};
          id = {2'b11, jj + {rnd_r[0], rnd_r[0]}};
          q  = qr_half(w_r[ia], w_r[ib], w_r[ic], w_r[id], half_r);
          w_nxt[ia] = q[127:96];
          w_nxt[ib] = q[95:64];
          w_nxt[ic] = q[63:32];
          w_nxt[id] = q[31:0];
        end
        half_nxt = !half_r;
        if (half_r) begin
          if (rnd_r == RndW'(NumRounds - 1)) begin
            state_nxt = S_FEED;
          end else begin
            rnd_nxt = rnd_r + 1'b1;
          end
        end
      end
      S_FEED: begin
        for (int i = 0; i < 16; i++) begin
          w_nxt[i] = w_r[i] + init_w[i];
        end
        blk_ctr_nxt = blk_ctr_r + 64'd1;
        fresh_nxt   = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pos_r    <= '0;
      in_msg_r <= 1'b0;
      fresh_r  <= 1'b0;
      rnd_r    <= '0;
      half_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pos_r    <= pos_nxt;
      in_msg_r <= in_msg_nxt;
      fresh_r  <= fresh_nxt;
      rnd_r    <= rnd_nxt;
      half_r   <= half_nxt;
    end
    w_r       <= w_nxt;
    blk_ctr_r <= blk_ctr_nxt;
  end

endmodule

>>> hw/rtl/chacha20_stream_xor_top.sv
// top level of the chacha20 stream xor block: config registers, queues and core
// path: a result goes through the front queue, the core's xor and the result queue when keystream
//   is on hand; a new 64-byte keystream block first needs load, 40 half rounds and feed-forward
// throughput: one byte per cycle inside a block while the result queue has room; bytes wait while
//   the single shared round unit in the core makes each new block
// reset: synchronous active-low rst_n empties both queues, clears config and message state

module chacha20_stream_xor_top import cc20sx_pkg::*; #(
  parameter int InDepth  = 4,
  parameter int OutDepth = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  // byte requests in
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_data_byte,
  input  logic               in_last_byte,
  // combined bytes out
  output logic               out_empty,
  input  logic               out_pop,
  output logic [7:0]         out_byte,
  output logic               out_last,
  // configuration writes
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [63:0]        cfg_wdata
);

  cfg_t  cfg_r;
  item_t in_wr_item;
  item_t in_rd_item;
  item_t core_out_item;
  item_t out_rd_item;
  logic  in_empty;
  logic  core_in_pop;
  logic  core_out_push;
  logic  out_full;

  // config register file; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgKey0:     cfg_r.key0      <= cfg_wdata;
        CfgKey1:     cfg_r.key1      <= cfg_wdata;
        CfgKey2:     cfg_r.key2      <= cfg_wdata;
        CfgKey3:     cfg_r.key3      <= cfg_wdata;
        CfgNonce:    cfg_r.nonce     <= cfg_wdata;
        CfgStartCtr: cfg_r.start_ctr <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign in_wr_item.data = in_data_byte;
  assign in_wr_item.last = in_last_byte;

  // front queue: takes requests while the core is busy with a block
  cc20sx_fifo #(
    .Width($bits(item_t)),
    .Depth(InDepth)
  ) u_in_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_data (in_wr_item),
    .full    (in_full),
    .pop     (core_in_pop),
    .rd_data (in_rd_item),
    .empty   (in_empty)
  );

  // back part: keystream rounds and the byte xor
  cc20sx_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_item  (in_rd_item),
    .in_valid (!in_empty),
    .in_pop   (core_in_pop),
    .out_item (core_out_item),
    .out_push (core_out_push),
    .out_full (out_full)
  );

  // result queue: decouples the consumer's stalls from the core
  cc20sx_fifo #(
    .Width($bits(item_t)),
    .Depth(OutDepth)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (core_out_push),
    .wr_data (core_out_item),
    .full    (out_full),
    .pop     (out_pop),
    .rd_data (out_rd_item),
    .empty   (out_empty)
  );

  assign out_byte = out_rd_item.data;
  assign out_last = out_rd_item.last;

endmodule

>>> hw/rtl/cc20sx_checker.sv
// port-level checks on the chacha20 stream xor top level, bound in below
module cc20sx_checker #(
  parameter int InDepth  = 4,
  parameter int OutDepth = 2
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_push,
  input logic               in_full,
  input logic               out_empty,
  input logic               out_pop,
  input logic [7:0]         out_byte,
  input logic               out_last
);

  localparam int Cap = InDepth + OutDepth;
  localparam int CW  = $clog2(Cap + 1) + 1;

  logic [CW-1:0] pend_r;
  logic          in_acc;
  logic          out_acc;

  assign in_acc  = in_push && !in_full;
  assign out_acc = out_pop && !out_empty;

  // requests taken but not yet handed out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (in_acc && !out_acc) begin
      pend_r <= pend_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      pend_r <= pend_r - 1'b1;
    end
  end

  // after reset the result queue is empty and the front queue is not full
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // no result without an outstanding request
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r == '0) |-> out_empty)
    else $error("result shown with no request pending");

  // storage bound: full must show once every slot holds a request
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r == CW'(Cap)) |-> in_full)
    else $error("input not full at capacity");

  // a stalled result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_byte) && $stable(out_last)))
    else $error("stalled result changed");

endmodule

bind chacha20_stream_xor_top cc20sx_checker #(
  .InDepth (InDepth),
  .OutDepth(OutDepth)
) u_cc20sx_checker (.*);
